// ===== hw/rtl/acm_pkg.sv =====
// Shared types, constants and AES helper functions for the AES-CMAC engine.
package acm_pkg;

  localparam int unsigned RowCount = 15;
  localparam int unsigned RowAddrW = 4;
  localparam logic [127:0] CmacRb = 128'h87;
  localparam logic [7:0] CmacPad = 8'h80;
  localparam logic [4:0] BlockBytes = 5'd16;

  localparam logic [1:0] KEY_128 = 2'd0;
  localparam logic [1:0] KEY_192 = 2'd1;
  localparam logic [1:0] KEY_256 = 2'd2;
  localparam logic [1:0] KEY_BAD = 2'd3;

  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_KSIZE = 3'd4;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [4:0]  valid_bytes;
    logic        last_block;
  } blk_item_t;

  typedef struct packed {
    logic [63:0] mac_high;
    logic [63:0] mac_low;
    logic        key_error;
  } mac_item_t;

  typedef struct packed {
    logic first;
    logic final_rnd;
  } rnd_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_OUT
  } state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [127:0] dbl(input logic [127:0] x);
    return {x[126:0], 1'b0} ^ (x[127] ? CmacRb : 128'h0);
  endfunction

endpackage

// ===== hw/rtl/aes_cmac_engine.sv =====
// AES-CMAC engine top level: APB key registers, key expansion, iterative AES, CMAC framing.
// First block of a message: key expansion, then L = E_K(0) in the round unit.
// Every block: accept, load, then the rounds in the shared round unit (Nr = 10, 12, 14),
// one round per cycle reading one round-key row; with an invalid key size only the accept.
// Last block: the MAC register loads in ST_OUT once the output is free. One item at a time.
// Sync reset clears control, keys and chain; round keys and L are rebuilt per message.
module aes_cmac_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  input  logic                blk_valid,
  output logic                blk_ready,
  input  acm_pkg::blk_item_t  blk,
  output logic                mac_valid,
  input  logic                mac_ready,
  output acm_pkg::mac_item_t  mac
);

  logic [63:0] kw0, kw1, kw2, kw3;
  logic [1:0]  ksize;
  logic [2:0]  reg_idx;

  acm_pkg::state_t state, state_next;
  acm_pkg::blk_item_t cur;
  logic         in_message, key_bad, gen_l;
  logic [3:0]   nk, nr, rnd;
  logic [5:0]   widx, wlast;
  logic [2:0]   kcnt;
  logic [7:0]   rc;
  logic [31:0]  win [8];
  logic [31:0]  rowbuf [3];
  logic [127:0] st, chain, lkey, st_rnd, msg_mod, msg_pad, k1, k2;
  logic [255:0] key_all;
  logic [31:0]  new_word, tw, back;
  logic         blk_acc, rnd_done;

  logic                          ram_we;
  logic [acm_pkg::RowAddrW-1:0]  ram_waddr, ram_raddr;
  logic [127:0]                  ram_wdata, ram_rdata;
  acm_pkg::rnd_ctrl_t            rctrl;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];

  always_comb begin
    unique case (reg_idx)
      acm_pkg::REG_KEY0:  prdata = kw0;
      acm_pkg::REG_KEY1:  prdata = kw1;
      acm_pkg::REG_KEY2:  prdata = kw2;
      acm_pkg::REG_KEY3:  prdata = kw3;
      acm_pkg::REG_KSIZE: prdata = {62'h0, ksize};
      default:            prdata = 64'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kw0 <= '0;
      kw1 <= '0;
      kw2 <= '0;
      kw3 <= '0;
      ksize <= acm_pkg::KEY_128;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        acm_pkg::REG_KEY0:  kw0 <= pwdata;
        acm_pkg::REG_KEY1:  kw1 <= pwdata;
        acm_pkg::REG_KEY2:  kw2 <= pwdata;
        acm_pkg::REG_KEY3:  kw3 <= pwdata;
        acm_pkg::REG_KSIZE: ksize <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // key schedule word generator
  assign key_all = {kw0, kw1, kw2, kw3};
  assign wlast   = {nr + 4'd1, 2'b00} - 6'd1;

  always_comb begin
    unique case (nk)
      4'd4:    back = win[4];
      4'd6:    back = win[2];
      default: back = win[0];
    endcase
    tw = win[7];
    if (kcnt == 3'd0) begin
      tw = acm_pkg::sub_word({win[7][23:0], win[7][31:24]}) ^ {rc, 24'h0};
    end else if (nk == 4'd8 && kcnt == 3'd4) begin
      tw = acm_pkg::sub_word(win[7]);
    end
    if (widx < {2'b00, nk}) begin
      new_word = key_all[255 - 32*widx[2:0] -: 32];
    end else begin
      new_word = back ^ tw;
    end
  end

  // CMAC last-block framing
  assign k1 = acm_pkg::dbl(lkey);
  assign k2 = acm_pkg::dbl(k1);

  always_comb begin
    logic [127:0] m;
    m = {cur.block_high, cur.block_low};
    for (int j = 0; j < 16; j++) begin
      if (5'(j) < cur.valid_bytes) begin
        msg_pad[127-8*j -: 8] = m[127-8*j -: 8];
      end else if (5'(j) == cur.valid_bytes) begin
        msg_pad[127-8*j -: 8] = acm_pkg::CmacPad;
      end else begin
        msg_pad[127-8*j -: 8] = 8'h00;
      end
    end
    if (!cur.last_block) begin
      msg_mod = m;
    end else if (cur.valid_bytes >= acm_pkg::BlockBytes) begin
      msg_mod = m ^ k1;
    end else begin
      msg_mod = msg_pad ^ k2;
    end
  end

  assign blk_acc  = blk_valid && blk_ready;
  assign rnd_done = (state == acm_pkg::ST_ROUND) && (rnd == nr);
  assign rctrl.first     = (rnd == 4'd0);
  assign rctrl.final_rnd = (rnd == nr);

  acm_round u_round (
    .state_in  (st),
    .rkey      (ram_rdata),
    .ctrl      (rctrl),
    .state_out (st_rnd)
  );

  acm_ram #(
    .Width (128),
    .Depth (acm_pkg::RowCount)
  ) u_rk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control outputs
  always_comb begin
    blk_ready = (state == acm_pkg::ST_IDLE);
    ram_we    = (state == acm_pkg::ST_EXPAND) && (widx[1:0] == 2'd3);
    ram_waddr = widx[5:2];
    ram_wdata = {rowbuf[0], rowbuf[1], rowbuf[2], new_word};
    if (state == acm_pkg::ST_ROUND && rnd != nr) begin
      ram_raddr = rnd + 4'd1;
    end else begin
      ram_raddr = '0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      acm_pkg::ST_IDLE: begin
        if (blk_acc) begin
          if (!in_message) begin
            if (ksize != acm_pkg::KEY_BAD) begin
              state_next = acm_pkg::ST_EXPAND;
            end else if (blk.last_block) begin
              state_next = acm_pkg::ST_OUT;
            end
          end else if (key_bad) begin
            if (blk.last_block) begin
              state_next = acm_pkg::ST_OUT;
            end
          end else begin
            state_next = acm_pkg::ST_LOAD;
          end
        end
      end
      acm_pkg::ST_EXPAND: begin
        if (widx == wlast) begin
          state_next = acm_pkg::ST_LOAD;
        end
      end
      acm_pkg::ST_LOAD: state_next = acm_pkg::ST_ROUND;
      acm_pkg::ST_ROUND: begin
        if (rnd == nr) begin
          if (gen_l) begin
            state_next = acm_pkg::ST_LOAD;
          end else if (cur.last_block) begin
            state_next = acm_pkg::ST_OUT;
          end else begin
            state_next = acm_pkg::ST_IDLE;
          end
        end
      end
      acm_pkg::ST_OUT: begin
        if (!mac_valid || mac_ready) begin
          state_next = acm_pkg::ST_IDLE;
        end
      end
      default: state_next = acm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= acm_pkg::ST_IDLE;
      in_message <= 1'b0;
      key_bad    <= 1'b0;
      gen_l      <= 1'b0;
      chain      <= '0;
      mac_valid  <= 1'b0;
      nk         <= 4'd4;
      nr         <= 4'd10;
      rnd        <= '0;
      widx       <= '0;
      kcnt       <= '0;
      rc         <= 8'h01;
    end else begin
      state <= state_next;
      if (state == acm_pkg::ST_OUT && (!mac_valid || mac_ready)) begin
        mac_valid <= 1'b1;
      end else if (mac_valid && mac_ready) begin
        mac_valid <= 1'b0;
      end
      unique case (state)
        acm_pkg::ST_IDLE: begin
          if (blk_acc) begin
            cur <= blk;
            if (!in_message) begin
              in_message <= 1'b1;
              key_bad    <= (ksize == acm_pkg::KEY_BAD);
              chain      <= '0;
              gen_l      <= 1'b1;
              widx       <= '0;
              kcnt       <= '0;
              rc         <= 8'h01;
              unique case (ksize)
                acm_pkg::KEY_192: begin nk <= 4'd6; nr <= 4'd12; end
                acm_pkg::KEY_256: begin nk <= 4'd8; nr <= 4'd14; end
                default:          begin nk <= 4'd4; nr <= 4'd10; end
              endcase
            end
          end
        end
        acm_pkg::ST_EXPAND: begin
          for (int k = 0; k < 7; k++) begin
            win[k] <= win[k+1];
          end
          win[7] <= new_word;
          if (widx[1:0] != 2'd3) begin
            rowbuf[widx[1:0]] <= new_word;
          end
          if (widx >= {2'b00, nk} && kcnt == 3'd0) begin
            rc <= acm_pkg::xt(rc);
          end
          kcnt <= (kcnt == nk[2:0] - 3'd1 && nk != 4'd8) || (kcnt == 3'd7) ?
                  3'd0 : kcnt + 3'd1;
          widx <= widx + 6'd1;
        end
        acm_pkg::ST_LOAD: begin
          st  <= gen_l ? 128'h0 : (chain ^ msg_mod);
          rnd <= '0;
        end
        acm_pkg::ST_ROUND: begin
          st  <= st_rnd;
          rnd <= rnd + 4'd1;
          if (rnd_done) begin
            if (gen_l) begin
              lkey  <= st_rnd;
              gen_l <= 1'b0;
            end else begin
              chain <= st_rnd;
            end
          end
        end
        acm_pkg::ST_OUT: begin
          if (!mac_valid || mac_ready) begin
            mac.mac_high  <= key_bad ? 64'h0 : st[127:64];
            mac.mac_low   <= key_bad ? 64'h0 : st[63:0];
            mac.key_error <= key_bad;
            in_message    <= 1'b0;
            chain         <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    mac_valid && mac.key_error |-> mac.mac_high == 64'h0 && mac.mac_low == 64'h0)
    else $error("key error tag not zero");

  a_we_expand: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == acm_pkg::ST_EXPAND && !blk_ready)
    else $error("round key write outside expansion");

  a_rnd_range: assert property (@(posedge clk) disable iff (rst)
    state == acm_pkg::ST_ROUND |-> rnd <= nr)
    else $error("round counter overrun");

  a_out_flag: assert property (@(posedge clk) disable iff (rst)
    state == acm_pkg::ST_OUT && (!mac_valid || mac_ready) |=> mac_valid && !in_message)
    else $error("tag not loaded");

endmodule

// ===== hw/rtl/acm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module acm_ram #(
  parameter int unsigned Width = 128,
  parameter int unsigned Depth = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/acm_round.sv =====
// One AES round: SubBytes, ShiftRows, MixColumns (not in the final round), AddRoundKey; first round: AddRoundKey only.
module acm_round (
  input  logic [127:0]       state_in,
  input  logic [127:0]       rkey,
  input  acm_pkg::rnd_ctrl_t ctrl,
  output logic [127:0]       state_out
);

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];
  logic [127:0] mixed;

  always_comb begin
    logic [7:0] a0, a1, a2, a3, x;
    for (int k = 0; k < 16; k++) begin
      s[k] = state_in[127-8*k -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c+r] = acm_pkg::SBOX[s[4*((c+r)%4)+r]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c+1];
      a2 = t[4*c+2];
      a3 = t[4*c+3];
      x = a0 ^ a1 ^ a2 ^ a3;
      m[4*c]   = a0 ^ x ^ acm_pkg::xt(a0 ^ a1);
      m[4*c+1] = a1 ^ x ^ acm_pkg::xt(a1 ^ a2);
      m[4*c+2] = a2 ^ x ^ acm_pkg::xt(a2 ^ a3);
      m[4*c+3] = a3 ^ x ^ acm_pkg::xt(a3 ^ a0);
    end
    for (int k = 0; k < 16; k++) begin
      mixed[127-8*k -: 8] = ctrl.final_rnd ? t[k] : m[k];
    end
    state_out = (ctrl.first ? state_in : mixed) ^ rkey;
  end

endmodule

// ===== dv/tb_aes_cmac_engine.sv =====
// Testbench for the AES-CMAC engine: APB key setup, random messages, scoreboarded MAC check.
module tb_aes_cmac_engine;
  timeunit 1ns;
  timeprecision 1ps;

  class mac_scoreboard;
    acm_pkg::mac_item_t pending[$];
    int errors;
    int macs;
    int bad_key_macs;

    function void note_block(acm_pkg::mac_item_t m, bit produces);
      if (produces) pending.push_back(m);
    endfunction

    function void check_mac(acm_pkg::mac_item_t got);
      acm_pkg::mac_item_t want;
      if (pending.size() == 0) begin
        $error("unexpected mac item %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      macs++;
      if (want.key_error) bad_key_macs++;
      if (got.mac_high !== want.mac_high) begin
        $error("mac_high expected %h actual %h", want.mac_high, got.mac_high);
        errors++;
      end
      if (got.mac_low !== want.mac_low) begin
        $error("mac_low expected %h actual %h", want.mac_low, got.mac_low);
        errors++;
      end
      if (got.key_error !== want.key_error) begin
        $error("key_error expected %b actual %b", want.key_error, got.key_error);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic blk_valid = 0;
  logic blk_ready;
  acm_pkg::blk_item_t blk = '0;
  logic mac_valid;
  logic mac_ready = 0;
  acm_pkg::mac_item_t mac;

  aes_cmac_engine dut (.*);

  always #5 clk = ~clk;

  mac_scoreboard sb = new();

  // predictor state
  logic [63:0] key_reg [4];
  logic [1:0] ksize_reg;
  logic [127:0] chain;
  logic [127:0] lval;
  logic [31:0] rk [60];
  logic msg_open;
  logic bad_key;
  int nrounds;
  int blocks_sent;
  int idle_cycles;
  bit wd_fail;

  function automatic logic [7:0] gmul2(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sbox_word(logic [31:0] w);
    return {acm_pkg::SBOX[w[31:24]], acm_pkg::SBOX[w[23:16]],
            acm_pkg::SBOX[w[15:8]], acm_pkg::SBOX[w[7:0]]};
  endfunction

  function automatic logic [127:0] aes_encrypt(logic [127:0] x);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, m;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) s[i] = x[127-8*i -: 8];
    for (int rd = 0; rd <= nrounds; rd++) begin
      if (rd > 0) begin
        for (int c = 0; c < 4; c++)
          for (int w = 0; w < 4; w++)
            t[4*c+w] = acm_pkg::SBOX[s[4*((c+w)&3)+w]];
        s = t;
        if (rd < nrounds)
          for (int c = 0; c < 4; c++) begin
            a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
            m = a0 ^ a1 ^ a2 ^ a3;
            s[4*c]   = a0 ^ m ^ gmul2(a0 ^ a1);
            s[4*c+1] = a1 ^ m ^ gmul2(a1 ^ a2);
            s[4*c+2] = a2 ^ m ^ gmul2(a2 ^ a3);
            s[4*c+3] = a3 ^ m ^ gmul2(a3 ^ a0);
          end
      end
      for (int c = 0; c < 4; c++)
        for (int b = 0; b < 4; b++)
          s[4*c+b] ^= rk[(rd*4+c)%60][31-8*b -: 8];
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
    return r;
  endfunction

  function automatic logic [127:0] shift_subkey(logic [127:0] x);
    return {x[126:0], 1'b0} ^ (x[127] ? 128'h87 : 128'h0);
  endfunction

  function automatic void load_key_schedule(int nk);
    logic [31:0] tw;
    logic [7:0] rcon;
    rcon = 8'h01;
    for (int i = 0; i < nk; i++)
      rk[i] = (i & 1) ? key_reg[i>>1][31:0] : key_reg[i>>1][63:32];
    for (int i = nk; i < 4*(nrounds+1) && i < 60; i++) begin
      tw = rk[i-1];
      if (i % nk == 0) begin
        tw = sbox_word({tw[23:0], tw[31:24]}) ^ {rcon, 24'h0};
        rcon = gmul2(rcon);
      end else if (nk > 6 && i % nk == 4) begin
        tw = sbox_word(tw);
      end
      rk[i] = rk[i-nk] ^ tw;
    end
  endfunction

  // returns 1 when this block closes a message; tag in m
  function automatic bit predict_block(acm_pkg::blk_item_t b, output acm_pkg::mac_item_t m);
    logic [127:0] d, k;
    int n;
    m = '0;
    if (!msg_open) begin
      bad_key = (ksize_reg == acm_pkg::KEY_BAD);
      if (!bad_key) begin
        nrounds = 10 + 2 * ksize_reg;
        load_key_schedule(4 + 2 * ksize_reg);
        lval = aes_encrypt(128'h0);
      end
      chain = '0;
      msg_open = 1;
    end
    d = {b.block_high, b.block_low};
    if (!b.last_block) begin
      if (!bad_key) chain = aes_encrypt(chain ^ d);
      return 0;
    end
    if (bad_key) begin
      m.key_error = 1;
    end else begin
      n = (b.valid_bytes > 16) ? 16 : b.valid_bytes;
      k = shift_subkey(lval);
      if (n < 16) begin
        k = shift_subkey(k);
        for (int i = 0; i < 16; i++)
          if (i > n) d[127-8*i -: 8] = 8'h00;
          else if (i == n) d[127-8*i -: 8] = 8'h80;
      end
      chain = aes_encrypt(chain ^ d ^ k);
      m.mac_high = chain[127:64];
      m.mac_low = chain[63:0];
    end
    chain = '0;
    msg_open = 0;
    return 1;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 6'(idx) << 3; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == acm_pkg::REG_KSIZE) ksize_reg = val[1:0];
    else key_reg[idx[1:0]] = val;
    @(posedge clk);
  endtask

  bit stall_mode;

  task automatic send_block(acm_pkg::blk_item_t b);
    acm_pkg::mac_item_t m;
    bit has_mac;
    int gap;
    gap = stall_mode ? gap_len() : 0;
    if (gap != 0) begin
      blk_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    blk_valid <= 1;
    blk <= b;
    @(posedge clk);
    while (!blk_ready) @(posedge clk);
    has_mac = predict_block(b, m);
    sb.note_block(m, has_mac);
    blocks_sent++;
  endtask

  function automatic acm_pkg::blk_item_t rand_block(bit last);
    acm_pkg::blk_item_t b;
    b.block_high = {$urandom, $urandom};
    b.block_low = {$urandom, $urandom};
    b.valid_bytes = last ? 5'($urandom_range(0, 16)) : 5'd16;
    if ($urandom_range(0, 19) == 0) b.valid_bytes = 5'($urandom_range(0, 31));
    b.last_block = last;
    return b;
  endfunction

  task automatic send_message(int nblk);
    for (int i = 0; i < nblk; i++) send_block(rand_block(i == nblk - 1));
  endtask

  task automatic drain();
    blk_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_key(logic [1:0] ks, bit extreme);
    for (int i = 0; i < 4; i++)
      write_reg(3'(i), extreme ? (ks[0] ? '1 : '0) : {$urandom, $urandom});
    write_reg(acm_pkg::REG_KSIZE, 64'(ks));
  endtask

  // output side: random backpressure in stall mode
  initial begin
    forever begin
      @(posedge clk);
      if (mac_valid && mac_ready) sb.check_mac(mac);
      mac_ready <= stall_mode ? ($urandom_range(0, 99) < 60) : 1'b1;
    end
  end

  // watchdog
  initial begin
    forever begin
      @(posedge clk);
      if ((blk_valid && blk_ready) || (mac_valid && mac_ready) || psel) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 20000) begin
        $display("aes_cmac_engine verification failed");
        $finish;
      end
    end
  end

  initial begin
    acm_pkg::blk_item_t b;
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    ksize_reg = acm_pkg::KEY_128;
    msg_open = 0; bad_key = 0; chain = '0; nrounds = 10;
    stall_mode = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // RFC 4493 example key, directed corner blocks
    write_reg(acm_pkg::REG_KEY0, 64'h2b7e151628aed2a6);
    write_reg(acm_pkg::REG_KEY1, 64'habf7158809cf4f3c);
    write_reg(acm_pkg::REG_KSIZE, 64'(acm_pkg::KEY_128));
    b = '0; b.last_block = 1;
    send_block(b);
    b.block_high = 64'h6bc1bee22e409f96; b.block_low = 64'he93d7e117393172a;
    b.valid_bytes = 5'd16;
    send_block(b);
    for (int n = 1; n <= 31; n += 5) begin
      b.valid_bytes = 5'(n); b.last_block = 1;
      b.block_high = '1; b.block_low = '1;
      send_block(b);
    end
    b = '0; b.valid_bytes = 5'd3; b.block_high = '1;
    send_block(b);
    b.valid_bytes = 5'd0; b.last_block = 1;
    send_block(b);
    // key change mid-message takes effect next message
    send_block(rand_block(0));
    blk_valid <= 0;
    @(posedge clk);
    while (!blk_ready) @(posedge clk);
    write_reg(acm_pkg::REG_KEY0, 64'h0123456789abcdef);
    send_block(rand_block(1));
    drain();

    for (int ks = 0; ks < 4; ks++) begin
      set_key(2'(ks), 1);
      send_message(1);
      send_message(3);
      drain();
    end

    stall_mode = 1;
    while (blocks_sent < 1700) begin
      set_key(2'($urandom_range(0, 9) == 0 ? acm_pkg::KEY_BAD : $urandom_range(0, 2)),
              $urandom_range(0, 9) == 0);
      stall_mode = $urandom_range(0, 4) != 0;
      for (int m = 0; m < 8; m++) send_message($urandom_range(1, 5));
      drain();
    end
    stall_mode = 0;
    drain();

    $display("covered %0d blocks, %0d tags (%0d with bad key size), all key sizes",
             blocks_sent, sb.macs, sb.bad_key_macs);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("aes_cmac_engine verification clean");
    end else begin
      $display("aes_cmac_engine verification failed");
    end
    $finish;
  end

endmodule
